>>> rtl/ppik_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ppik_pkg: shared constants and helpers for the platform kinematics core
// Holds the CORDIC arctangent table, the CORDIC start value and a rounding helper.
// ----------------------------------------------------------------------------
package ppik_pkg;

    localparam int CORDIC_STEPS = 30;

    // Gain-compensated CORDIC start value in Q30.
    localparam logic signed [33:0] X_INIT = 34'sd652032874;

    // Arctangent of 2^-i in 32-bit turns.
    function automatic logic [31:0] atan_turn(input logic [4:0] idx);
        logic [31:0] v;
        unique case (idx)
            5'd0:  v = 32'h20000000;
            5'd1:  v = 32'h12E4051E;
            5'd2:  v = 32'h09FB385B;
            5'd3:  v = 32'h051111D4;
            5'd4:  v = 32'h028B0D43;
            5'd5:  v = 32'h0145D7E1;
            5'd6:  v = 32'h00A2F61E;
            5'd7:  v = 32'h00517C55;
            5'd8:  v = 32'h0028BE53;
            5'd9:  v = 32'h00145F2F;
            5'd10: v = 32'h000A2F98;
            5'd11: v = 32'h000517CC;
            5'd12: v = 32'h00028BE6;
            5'd13: v = 32'h000145F3;
            5'd14: v = 32'h0000A2FA;
            5'd15: v = 32'h0000517D;
            5'd16: v = 32'h000028BE;
            5'd17: v = 32'h0000145F;
            5'd18: v = 32'h00000A30;
            5'd19: v = 32'h00000518;
            5'd20: v = 32'h0000028C;
            5'd21: v = 32'h00000146;
            5'd22: v = 32'h000000A3;
            5'd23: v = 32'h00000051;
            5'd24: v = 32'h00000029;
            5'd25: v = 32'h00000014;
            5'd26: v = 32'h0000000A;
            5'd27: v = 32'h00000005;
            5'd28: v = 32'h00000003;
            5'd29: v = 32'h00000001;
            default: v = 32'h00000000;
        endcase
        return v;
    endfunction

    // Q30 x Q30 sum back to Q30, rounding half up.
    function automatic logic signed [31:0] rnd_q30(input logic signed [64:0] v);
        logic signed [64:0] t;
        t = v + 65'sd536870912;
        return t[61:30];
    endfunction

endpackage
`default_nettype wire

>>> rtl/parallel_platform_inverse_kinematics_core.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// parallel_platform_inverse_kinematics_core: pose to joint positions
// Rotates six platform joint points by a ZYX Euler pose and translates them.
// ----------------------------------------------------------------------------
// Usage:
// A pose beat (translation in signed fixed point, three binary angles) is
// accepted when i_valid and o_ready are both high. One result beat of six
// saturated joint coordinates leaves when o_valid and i_ready are both high.
// Every pose gives exactly one result, in order.
// Throughput is one pose per clock cycle when the output does not stall.
// Thirty of the stages are the one-iteration-per-stage CORDIC pipelines
// that form sine and cosine of all three angles at once. The remaining
// stages undo the angle fold, form the rotation matrix with registered
// multipliers, scale by the joint offset and round, add and saturate.
// The pipeline advances as one: when a result waits at the output and the
// receiver holds i_ready low, every stage holds and o_ready drops, so
// nothing is lost or repeated. Empty output slots never stall the pipeline.
// Reset (i_rst_n low at a clock edge) empties the pipeline and sets the
// joint offset back to 32. The offset is written through i_cfg_we and
// i_cfg_data and should change only while no pose is in flight.
// ----------------------------------------------------------------------------
module parallel_platform_inverse_kinematics_core #(
    parameter int FRAC_BITS  = 16,
    parameter int ANGLE_BITS = 16
) (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  wire                          i_cfg_we,
    input  wire        [9:0]             i_cfg_data,
    input  wire                          i_valid,
    output logic                         o_ready,
    input  wire signed [31:0]            i_pos_x,
    input  wire signed [31:0]            i_pos_y,
    input  wire signed [31:0]            i_pos_z,
    input  wire signed [ANGLE_BITS-1:0]  i_angle_phi,
    input  wire signed [ANGLE_BITS-1:0]  i_angle_theta,
    input  wire signed [ANGLE_BITS-1:0]  i_angle_psi,
    output logic                         o_valid,
    input  wire                          i_ready,
    output logic signed [31:0]           o_leg_one,
    output logic signed [31:0]           o_leg_two,
    output logic signed [31:0]           o_leg_three,
    output logic signed [31:0]           o_leg_four,
    output logic signed [31:0]           o_leg_five,
    output logic signed [31:0]           o_leg_six
);

    localparam int STEPS = ppik_pkg::CORDIC_STEPS;
    // Stage positions in the pipeline.
    localparam int PN  = STEPS + 1;  // sine and cosine sign fix
    localparam int PA  = STEPS + 2;  // Rz*Ry products
    localparam int PB  = STEPS + 3;  // Rz*Ry rounding
    localparam int PC  = STEPS + 4;  // (Rz*Ry)*Rx products
    localparam int PD  = STEPS + 5;  // rotation rounding
    localparam int PE  = STEPS + 6;  // joint combinations
    localparam int PF  = STEPS + 7;  // offset scaling
    localparam int LAT = STEPS + 8;  // output register
    localparam int SH  = 30 - FRAC_BITS;

    logic w_en;
    logic r_vld [0:LAT];
    logic [9:0] r_offset;

    assign w_en    = ~r_vld[LAT] | i_ready;
    assign o_ready = w_en;
    assign o_valid = r_vld[LAT];

    // Configuration register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_offset <= 10'd32;
        end else if (i_cfg_we) begin
            r_offset <= i_cfg_data;
        end
    end

    // Valid bits travel with the data.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k <= LAT; k++) r_vld[k] <= 1'b0;
        end else if (w_en) begin
            r_vld[0] <= i_valid;
            for (int k = 1; k <= LAT; k++) r_vld[k] <= r_vld[k-1];
        end
    end

    // Translation rides alongside until the final add.
    logic signed [31:0] r_tr [0:LAT-1][0:2];
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_tr[0][0] <= i_pos_x;
            r_tr[0][1] <= i_pos_y;
            r_tr[0][2] <= i_pos_z;
            for (int k = 1; k < LAT; k++) r_tr[k] <= r_tr[k-1];
        end
    end

    // ------------------------------------------------------------------
    // CORDIC: three rotators (phi, theta, psi), one iteration per stage.
    // ------------------------------------------------------------------
    logic signed [33:0] r_x    [0:STEPS][0:2];
    logic signed [33:0] r_y    [0:STEPS][0:2];
    logic signed [33:0] r_z    [0:STEPS][0:2];
    logic               r_flip [0:STEPS][0:2];

    logic [ANGLE_BITS-1:0] w_ang [0:2];
    assign w_ang[0] = i_angle_phi;
    assign w_ang[1] = i_angle_theta;
    assign w_ang[2] = i_angle_psi;

    for (genvar a = 0; a < 3; a++) begin : g_pre
        logic [31:0] n_turn;
        logic [31:0] n_quad;
        logic        n_flip;
        always_comb begin
            // Widen to a 32-bit turn and fold the back half-plane forward.
            n_turn = {w_ang[a], {(32 - ANGLE_BITS){1'b0}}};
            n_quad = n_turn + 32'h4000_0000;
            n_flip = n_quad[31];
            if (n_flip) begin
                n_turn = n_turn ^ 32'h8000_0000;
            end
        end
        always_ff @(posedge i_clk) begin
            if (w_en) begin
                r_x[0][a]    <= ppik_pkg::X_INIT;
                r_y[0][a]    <= '0;
                r_z[0][a]    <= 34'(signed'(n_turn));
                r_flip[0][a] <= n_flip;
            end
        end
    end

    for (genvar k = 1; k <= STEPS; k++) begin : g_cordic
        for (genvar a = 0; a < 3; a++) begin : g_rot
            logic signed [33:0] n_x;
            logic signed [33:0] n_y;
            logic signed [33:0] n_z;
            logic signed [33:0] w_at;
            assign w_at = 34'(signed'({1'b0, ppik_pkg::atan_turn(5'(k - 1))}));
            always_comb begin
                if (!r_z[k-1][a][33]) begin
                    n_x = r_x[k-1][a] - (r_y[k-1][a] >>> (k - 1));
                    n_y = r_y[k-1][a] + (r_x[k-1][a] >>> (k - 1));
                    n_z = r_z[k-1][a] - w_at;
                end else begin
                    n_x = r_x[k-1][a] + (r_y[k-1][a] >>> (k - 1));
                    n_y = r_y[k-1][a] - (r_x[k-1][a] >>> (k - 1));
                    n_z = r_z[k-1][a] + w_at;
                end
            end
            always_ff @(posedge i_clk) begin
                if (w_en) begin
                    r_x[k][a]    <= n_x;
                    r_y[k][a]    <= n_y;
                    r_z[k][a]    <= n_z;
                    r_flip[k][a] <= r_flip[k-1][a];
                end
            end
        end
    end

    // Undo the half-turn fold: negate sine and cosine.
    logic signed [31:0] r_sin [0:2];
    logic signed [31:0] r_cos [0:2];
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int a = 0; a < 3; a++) begin
                r_sin[a] <= r_flip[STEPS][a] ? 32'(-r_y[STEPS][a]) : 32'(r_y[STEPS][a]);
                r_cos[a] <= r_flip[STEPS][a] ? 32'(-r_x[STEPS][a]) : 32'(r_x[STEPS][a]);
            end
        end
    end

    // ------------------------------------------------------------------
    // Rz*Ry: four true products, the rest are copies or negations.
    // ------------------------------------------------------------------
    logic signed [63:0] r_pa [0:3];
    logic signed [31:0] r_a_sin [0:2];
    logic signed [31:0] r_a_cos [0:2];
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_pa[0] <= r_cos[0] * r_cos[1];
            r_pa[1] <= r_cos[0] * r_sin[1];
            r_pa[2] <= r_sin[0] * r_cos[1];
            r_pa[3] <= r_sin[0] * r_sin[1];
            r_a_sin <= r_sin;
            r_a_cos <= r_cos;
        end
    end

    // tm holds Rz*Ry; row two column one is always zero.
    logic signed [31:0] r_tm [0:2][0:2];
    logic signed [31:0] r_b_ss;
    logic signed [31:0] r_b_cs;
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_tm[0][0] <= ppik_pkg::rnd_q30(65'(r_pa[0]));
            r_tm[0][1] <= -r_a_sin[0];
            r_tm[0][2] <= ppik_pkg::rnd_q30(65'(r_pa[1]));
            r_tm[1][0] <= ppik_pkg::rnd_q30(65'(r_pa[2]));
            r_tm[1][1] <= r_a_cos[0];
            r_tm[1][2] <= ppik_pkg::rnd_q30(65'(r_pa[3]));
            r_tm[2][0] <= -r_a_sin[1];
            r_tm[2][1] <= '0;
            r_tm[2][2] <= r_a_cos[1];
            r_b_ss     <= r_a_sin[2];
            r_b_cs     <= r_a_cos[2];
        end
    end

    // ------------------------------------------------------------------
    // (Rz*Ry)*Rx: column zero passes through for rows one and two (row zero is set to zero), columns one and two mix.
    // ------------------------------------------------------------------
    logic signed [63:0] r_pc [0:2][0:3];
    logic signed [31:0] r_c_col0 [1:2];
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int i = 0; i < 3; i++) begin
                r_pc[i][0] <= r_tm[i][1] * r_b_cs;
                r_pc[i][1] <= r_tm[i][2] * r_b_ss;
                r_pc[i][2] <= r_tm[i][1] * r_b_ss;
                r_pc[i][3] <= r_tm[i][2] * r_b_cs;
            end
            r_c_col0[1] <= r_tm[1][0];
            r_c_col0[2] <= r_tm[2][0];
        end
    end

    logic signed [31:0] r_rot [0:2][0:2];
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int i = 0; i < 3; i++) begin
                r_rot[i][1] <= ppik_pkg::rnd_q30(65'(r_pc[i][0]) + 65'(r_pc[i][1]));
                r_rot[i][2] <= ppik_pkg::rnd_q30(65'(r_pc[i][3]) - 65'(r_pc[i][2]));
            end
            r_rot[0][0] <= '0;
            r_rot[1][0] <= r_c_col0[1];
            r_rot[2][0] <= r_c_col0[2];
        end
    end

    // ------------------------------------------------------------------
    // Joint sums: each joint's signed row sum, later times the offset.
    // ------------------------------------------------------------------
    logic signed [33:0] r_js [0:5];
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_js[0] <= -(34'(r_rot[0][1]) + 34'(r_rot[0][2]));
            r_js[1] <= 34'(r_rot[0][2]) - 34'(r_rot[0][1]);
            r_js[2] <= 34'(r_rot[1][2]) - 34'(r_rot[1][0]);
            r_js[3] <= 34'(r_rot[1][0]) + 34'(r_rot[1][2]);
            r_js[4] <= -(34'(r_rot[2][0]) + 34'(r_rot[2][1]));
            r_js[5] <= 34'(r_rot[2][1]) - 34'(r_rot[2][0]);
        end
    end

    logic signed [44:0] r_jm [0:5];
    logic signed [10:0] w_off_s;
    assign w_off_s = signed'({1'b0, r_offset});
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int j = 0; j < 6; j++) r_jm[j] <= 45'(r_js[j]) * 45'(w_off_s);
        end
    end

    // Round to output format, add translation, saturate.
    logic signed [44:0] n_rnd [0:5];
    logic signed [45:0] n_sum [0:5];
    logic signed [31:0] n_leg [0:5];
    logic signed [31:0] r_leg [0:5];
    always_comb begin
        for (int j = 0; j < 6; j++) begin
            n_rnd[j] = (r_jm[j] + (45'sd1 <<< (SH - 1))) >>> SH;
            n_sum[j] = 46'(n_rnd[j]) + 46'(r_tr[LAT-1][j / 2]);
            if (n_sum[j] > 46'sd2147483647) begin
                n_leg[j] = 32'sh7FFF_FFFF;
            end else if (n_sum[j] < -46'sd2147483648) begin
                n_leg[j] = 32'sh8000_0000;
            end else begin
                n_leg[j] = n_sum[j][31:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_leg <= n_leg;
        end
    end

    assign o_leg_one   = r_leg[0];
    assign o_leg_two   = r_leg[1];
    assign o_leg_three = r_leg[2];
    assign o_leg_four  = r_leg[3];
    assign o_leg_five  = r_leg[4];
    assign o_leg_six   = r_leg[5];

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_reset_empty: assert property (@(posedge i_clk) !i_rst_n |=> !o_valid)
        else $error("output valid right after reset");

    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_en |=> $stable(r_vld[PA]) && $stable(r_vld[PD]) && $stable(o_valid))
        else $error("pipeline moved during a stall");

    a_accept_enters: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_ready |=> r_vld[0])
        else $error("accepted pose did not enter the pipeline");

    a_flow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_en && r_vld[PF] |=> o_valid)
        else $error("pose dropped before the output register");

    // Stage markers referenced so the stage map stays documented in code.
    a_mid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_en && r_vld[PN] && r_vld[PB] && r_vld[PC] && r_vld[PE] |=> r_vld[PN+1])
        else $error("pose lost inside the matrix stages");

endmodule
`default_nettype wire

>>> bench/tb_parallel_platform_inverse_kinematics_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_parallel_platform_inverse_kinematics_core: self-checking bench
// Drives pose beats, predicts the six joint coordinates with a behavioral
// CORDIC and matrix model, and compares every result beat in order.
// ----------------------------------------------------------------------------
module tb_parallel_platform_inverse_kinematics_core;

    localparam int FRAC_BITS  = 16;
    localparam int ANGLE_BITS = 16;
    localparam int LATENCY    = 39;
    localparam int IDLE_LIMIT = 5000;

    typedef struct packed {
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] pos_z;
        logic signed [15:0] phi;
        logic signed [15:0] theta;
        logic signed [15:0] psi;
    } pose_t;

    typedef struct packed {
        logic signed [31:0] leg_one;
        logic signed [31:0] leg_two;
        logic signed [31:0] leg_three;
        logic signed [31:0] leg_four;
        logic signed [31:0] leg_five;
        logic signed [31:0] leg_six;
    } joints_t;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_we = 1'b0;
    logic [9:0]  i_cfg_data = '0;
    logic        i_valid = 1'b0;
    logic        o_ready;
    pose_t       pose_drv = '0;
    logic        o_valid;
    logic        i_ready = 1'b0;
    joints_t     leg_out;

    // Predictor copy of the offset register and the store of expected joints.
    logic [9:0]  offset_shadow = 10'd32;
    joints_t     joints_pending[$];
    int          mismatch_count = 0;
    int          idle_cycles = 0;
    bit          sink_idle_enable = 1'b1;
    bit          src_idle_enable = 1'b1;
    int          hold_off_cycles = 0;

    always #10 i_clk = ~i_clk;

    parallel_platform_inverse_kinematics_core #(
        .FRAC_BITS(FRAC_BITS), .ANGLE_BITS(ANGLE_BITS)
    ) dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_we(i_cfg_we), .i_cfg_data(i_cfg_data),
        .i_valid(i_valid), .o_ready(o_ready),
        .i_pos_x(pose_drv.pos_x), .i_pos_y(pose_drv.pos_y), .i_pos_z(pose_drv.pos_z),
        .i_angle_phi(pose_drv.phi), .i_angle_theta(pose_drv.theta),
        .i_angle_psi(pose_drv.psi),
        .o_valid(o_valid), .i_ready(i_ready),
        .o_leg_one(leg_out.leg_one), .o_leg_two(leg_out.leg_two),
        .o_leg_three(leg_out.leg_three), .o_leg_four(leg_out.leg_four),
        .o_leg_five(leg_out.leg_five), .o_leg_six(leg_out.leg_six)
    );

    // Floor shift and round-half-up shift on 64-bit signed values.
    function automatic longint asr(input longint v, input int s);
        return v >>> s;
    endfunction

    function automatic longint round_asr(input longint v, input int s);
        return (v + (64'sd1 <<< (s - 1))) >>> s;
    endfunction

    function automatic longint atan_step(input int i);
        longint tbl[30] = '{
            64'h20000000, 64'h12E4051E, 64'h09FB385B, 64'h051111D4, 64'h028B0D43,
            64'h0145D7E1, 64'h00A2F61E, 64'h00517C55, 64'h0028BE53, 64'h00145F2F,
            64'h000A2F98, 64'h000517CC, 64'h00028BE6, 64'h000145F3, 64'h0000A2FA,
            64'h0000517D, 64'h000028BE, 64'h0000145F, 64'h00000A30, 64'h00000518,
            64'h0000028C, 64'h00000146, 64'h000000A3, 64'h00000051, 64'h00000029,
            64'h00000014, 64'h0000000A, 64'h00000005, 64'h00000003, 64'h00000001};
        return tbl[i];
    endfunction

    // Sine and cosine in Q30. Angles in the back half plane are turned by
    // half a circle first, and the results negated.
    task automatic cordic_sin_cos(input logic [15:0] ang, output longint s,
                                  output longint c);
        logic [31:0] turn;
        logic [31:0] probe;
        bit          flip;
        longint      x;
        longint      y;
        longint      z;
        longint      t;
        turn  = {ang, 16'h0};
        probe = turn + 32'h40000000;
        flip  = probe[31];
        if (flip) begin
            turn = turn - 32'h80000000;
        end
        x = 652032874;
        y = 0;
        z = longint'($signed(turn));
        for (int i = 0; i < 30; i++) begin
            t = x;
            if (z >= 0) begin
                x = x - asr(y, i);
                y = y + asr(t, i);
                z = z - atan_step(i);
            end else begin
                x = x + asr(y, i);
                y = y - asr(t, i);
                z = z + atan_step(i);
            end
        end
        s = flip ? -y : y;
        c = flip ? -x : x;
    endtask

    function automatic logic signed [31:0] clamp32(input longint v);
        if (v > 64'sd2147483647) return 32'sh7FFFFFFF;
        if (v < -64'sd2147483648) return 32'sh80000000;
        return v[31:0];
    endfunction

    // Rotate the six joint points by Rz*Ry*Rx and translate them.
    task automatic predict_joints(input pose_t p, output joints_t j);
        longint sp, cp, st, ct, ss, cs;
        longint rz[3][3];
        longint ry[3][3];
        longint rx[3][3];
        longint tm[3][3];
        longint rot[3][3];
        longint acc;
        longint off;
        longint trans[3];
        int     sgn[6][3];
        int     axis[6];
        logic signed [31:0] leg[6];
        sgn = '{'{0, -1, -1}, '{0, -1, 1}, '{-1, 0, 1}, '{1, 0, 1}, '{-1, -1, 0},
                '{-1, 1, 0}};
        axis = '{0, 0, 1, 1, 2, 2};
        cordic_sin_cos(p.phi, sp, cp);
        cordic_sin_cos(p.theta, st, ct);
        cordic_sin_cos(p.psi, ss, cs);
        rz = '{'{cp, -sp, 0}, '{sp, cp, 0}, '{0, 0, 64'sd1 <<< 30}};
        ry = '{'{ct, 0, st}, '{0, 64'sd1 <<< 30, 0}, '{-st, 0, ct}};
        rx = '{'{64'sd1 <<< 30, 0, 0}, '{0, cs, -ss}, '{0, ss, cs}};
        for (int r = 0; r < 3; r++) begin
            for (int q = 0; q < 3; q++) begin
                acc = 0;
                for (int k = 0; k < 3; k++) acc += rz[r][k] * ry[k][q];
                tm[r][q] = round_asr(acc, 30);
            end
        end
        for (int r = 0; r < 3; r++) begin
            for (int q = 0; q < 3; q++) begin
                acc = 0;
                for (int k = 0; k < 3; k++) acc += tm[r][k] * rx[k][q];
                rot[r][q] = round_asr(acc, 30);
            end
        end
        trans = '{longint'(p.pos_x), longint'(p.pos_y), longint'(p.pos_z)};
        off = longint'(offset_shadow);
        for (int n = 0; n < 6; n++) begin
            acc = 0;
            for (int k = 0; k < 3; k++) acc += rot[axis[n]][k] * (sgn[n][k] * off);
            leg[n] = clamp32(round_asr(acc, 30 - FRAC_BITS) + trans[axis[n]]);
        end
        j = '{leg[0], leg[1], leg[2], leg[3], leg[4], leg[5]};
    endtask

    // Offers one pose beat, with an optional random gap before it.
    task automatic send_pose(input pose_t p);
        joints_t exp_j;
        if (src_idle_enable && $urandom_range(0, 3) == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(negedge i_clk);
        end
        pose_drv <= p;
        i_valid  <= 1'b1;
        predict_joints(p, exp_j);
        do @(posedge i_clk); while (!o_ready);
        joints_pending.push_back(exp_j);
        @(negedge i_clk);
    endtask

    task automatic end_of_traffic();
        i_valid <= 1'b0;
    endtask

    task automatic drain_pipeline();
        end_of_traffic();
        while (joints_pending.size() != 0) @(negedge i_clk);
        repeat (LATENCY + 4) @(negedge i_clk);
    endtask

    task automatic write_offset(input logic [9:0] value);
        drain_pipeline();
        i_cfg_we   <= 1'b1;
        i_cfg_data <= value;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        offset_shadow = value;
    endtask

    function automatic logic [15:0] rand_angle();
        logic [15:0] special[8] = '{16'h0000, 16'h4000, 16'hC000, 16'h8000,
                                     16'h7FFF, 16'h3FFF, 16'h4001, 16'hBFFF};
        return ($urandom_range(0, 4) == 0) ? special[$urandom_range(0, 7)]
                                           : 16'($urandom);
    endfunction

    function automatic logic [31:0] rand_pos();
        case ($urandom_range(0, 5))
            0: return 32'h7FFFFFFF - $urandom_range(0, 1 << 26);
            1: return 32'h80000000 + $urandom_range(0, 1 << 26);
            2: return $urandom_range(0, 1 << 22) - (1 << 21);
            default: return $urandom;
        endcase
    endfunction

    function automatic pose_t rand_pose();
        return '{rand_pos(), rand_pos(), rand_pos(), rand_angle(), rand_angle(),
                 rand_angle()};
    endfunction

    // Extremes of every field, the quadrant boundaries of the angle fold, and
    // translations that push the sums into saturation, then six random poses.
    task automatic test_directed_extremes();
        pose_t p;
        send_pose('0);
        send_pose('{32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 16'h0, 16'h0, 16'h0});
        send_pose('{32'h80000000, 32'h80000000, 32'h80000000, 16'h0, 16'h0, 16'h0});
        send_pose('{32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF,
                    16'h8000, 16'h8000, 16'h8000});
        send_pose('{32'h80000000, 32'h7FFFFFFF, 32'h80000000,
                    16'h7FFF, 16'h7FFF, 16'h7FFF});
        send_pose('{32'hFFFFFFFF, 32'h1, 32'h10000, 16'h4000, 16'hC000, 16'h4000});
        send_pose('{32'h0, 32'h0, 32'h0, 16'hC000, 16'h4000, 16'hC000});
        send_pose('{32'h12345678, 32'hEDCBA987, 32'h0, 16'h3FFF, 16'h4001, 16'hBFFF});
        send_pose('{32'h0, 32'h0, 32'h0, 16'hC001, 16'hBFFF, 16'h4001});
        send_pose('{32'h55555555, 32'hAAAAAAAA, 32'h5A5A5A5A,
                    16'h5555, 16'hAAAA, 16'h0001});
        for (int i = 0; i < 6; i++) begin
            p = rand_pose();
            send_pose(p);
        end
    endtask

    task automatic test_random_poses(input int count);
        for (int i = 0; i < count; i++) send_pose(rand_pose());
    endtask

    // The receiver holds off long enough for the pipeline to fill and stall
    // the input while the sender keeps offering beats.
    task automatic test_backpressure();
        hold_off_cycles = 120;
        test_random_poses(60);
    endtask

    task automatic test_offset_settings();
        logic [9:0] sweep[4] = '{10'd1023, 10'd0, 10'd1, 10'd517};
        foreach (sweep[i]) begin
            write_offset(sweep[i]);
            test_random_poses(40);
        end
    endtask

    initial begin
        repeat (6) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        test_directed_extremes();
        test_random_poses(150);
        drain_pipeline();
        test_backpressure();
        test_offset_settings();
        write_offset(10'd32);
        // Final stretch runs at full rate on both sides.
        src_idle_enable  = 1'b0;
        sink_idle_enable = 1'b0;
        test_random_poses(80);
        drain_pipeline();
        if (mismatch_count == 0) begin
            $display("** parallel_platform_inverse_kinematics_core: PASSED **");
        end else begin
            $display("** parallel_platform_inverse_kinematics_core: FAILED **");
        end
        $finish;
    end

    // Receiver ready: random stall bursts, plus a long requested hold-off.
    initial begin
        int burst;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            if (hold_off_cycles > 0) begin
                i_ready <= 1'b0;
                repeat (hold_off_cycles) @(negedge i_clk);
                hold_off_cycles = 0;
                i_ready <= 1'b1;
            end else if (sink_idle_enable && $urandom_range(0, 5) == 0) begin
                burst = $urandom_range(1, 9);
                i_ready <= 1'b0;
                repeat (burst - 1) @(negedge i_clk);
            end else begin
                i_ready <= 1'b1;
            end
        end
    end

    // Result checker: compare every accepted beat with the oldest prediction.
    always @(posedge i_clk) begin
        joints_t exp_j;
        if (i_rst_n && o_valid && i_ready) begin
            if (joints_pending.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 10) begin
                    $display("Unexpected result beat at %0t", $realtime);
                end
            end else begin
                exp_j = joints_pending.pop_front();
                if (exp_j !== leg_out) begin
                    mismatch_count++;
                    if (mismatch_count <= 10) begin
                        $display("Mismatch at %0t: exp %h %h %h %h %h %h got %h %h %h %h %h %h",
                            $realtime, exp_j.leg_one, exp_j.leg_two, exp_j.leg_three,
                            exp_j.leg_four, exp_j.leg_five, exp_j.leg_six,
                            leg_out.leg_one, leg_out.leg_two, leg_out.leg_three,
                            leg_out.leg_four, leg_out.leg_five, leg_out.leg_six);
                    end
                end
            end
        end
    end

    // Watchdog: ends the run if no beat moves for too long.
    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready) || !i_rst_n) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("** parallel_platform_inverse_kinematics_core: FAILED **");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

endmodule

>>> sim.f
rtl/ppik_pkg.sv
rtl/parallel_platform_inverse_kinematics_core.sv
bench/tb_parallel_platform_inverse_kinematics_core.sv
